@@ src/fba_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fba_pkg: shared types and constants of the frame bitmap allocator
// Defaults for the bitmap geometry, result status codes and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package fba_pkg;

  // default bitmap geometry (WORD_BITS must be a power of two)
  localparam int unsigned NUM_FRAMES_DEF = 4096;
  localparam int unsigned WORD_BITS_DEF  = 32;

  // fixed field widths
  localparam int unsigned FRAME_W = 12;
  localparam int unsigned STAT_W  = 2;

  // request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOP  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  // controller -> datapath commands
  typedef struct packed {
    logic load_req;    // latch the incoming request
    logic set_nop;     // result: nothing to do
    logic free_rd;     // read the word holding the freed frame
    logic free_mod;    // clear the frame bit, stage the write
    logic scan_start;  // read bitmap word 0
    logic scan_step;   // check current word, read the next one
    logic commit;      // write staged word, load result register
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic is_free;     // latched request is a free
    logic frame_zero;  // page holds no frame
    logic frame_bad;   // frame outside the bitmap
    logic scan_stop;   // current word has a free bit, or it is the last word
    logic out_free;    // result register can take a new result
  } sts_t;

endpackage
`default_nettype wire

@@ src/fba_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fba_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module fba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/fba_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fba_dp: allocator datapath
// Bitmap RAM with per-word valid bits, word scan with lowest-free-bit
// encoder, free read-modify-write and the result register.
// ----------------------------------------------------------------------------
module fba_dp #(
  parameter int unsigned NUM_FRAMES = fba_pkg::NUM_FRAMES_DEF,
  parameter int unsigned WORD_BITS  = fba_pkg::WORD_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [0:0]   s_tuser,   // [0] req_type
  input  wire logic [15:0]  s_tdata,   // [11:0] page_frame, [12] kernel_page,
                                       // [13] writable_page
  input  wire fba_pkg::cmd_t cmd,
  output fba_pkg::sts_t     sts,
  input  wire logic         m_tready,
  output logic              m_tvalid,
  output logic [1:0]        m_tuser,   // [1:0] status
  output logic [15:0]       m_tdata    // [11:0] frame_out, [12] present, [13] rw, [14] user
);

  localparam int unsigned MAP_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned BW = $clog2(WORD_BITS);
  localparam int unsigned CW = AW + BW;
  localparam int unsigned FW = fba_pkg::FRAME_W;

  // latched request
  logic          req_type;
  logic [FW-1:0] page_frame;
  logic          kernel_page;
  logic          is_wr;

  // bitmap access
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        rd_addr_q;
  logic [WORD_BITS-1:0] rdata;
  logic [MAP_WORDS-1:0] valid_map;
  logic                 wr_pend;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  // pending result
  logic [1:0]    res_status;
  logic [FW-1:0] res_frame;
  logic          res_present;
  logic          res_rw;
  logic          res_user;

  // scan / free helpers
  logic [WORD_BITS-1:0] eff_word;
  logic                 word_full;
  logic [BW-1:0]        hit_bit;
  logic [CW-1:0]        hit_frame;
  logic [CW+FW-1:0]     hit_ext;
  logic                 hit_in_range;
  logic                 last_word;
  logic [AW+FW-1:0]     pf_ext;
  logic [AW-1:0]        free_idx;
  logic [WORD_BITS-1:0] set_word;
  logic [WORD_BITS-1:0] clr_word;

  // bitmap storage
  fba_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(MAP_WORDS),
    .AW   (AW)
  ) u_map (
    .clk  (clk),
    .we   (cmd.commit & wr_pend),
    .waddr(wr_addr),
    .wdata(wr_data),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  // word index of the frame being freed
  assign pf_ext   = {{AW{1'b0}}, page_frame};
  assign free_idx = pf_ext[BW +: AW];

  // read address select
  always_comb begin
    rd_addr = rd_addr_q;
    if (cmd.free_rd) begin
      rd_addr = free_idx;
    end else if (cmd.scan_start) begin
      rd_addr = '0;
    end else if (cmd.scan_step) begin
      rd_addr = rd_addr_q + AW'(1);
    end
  end

  // word as seen after reset: unwritten words are free, word 0 holds frame 0
  always_comb begin
    if (valid_map[rd_addr_q]) begin
      eff_word = rdata;
    end else if (rd_addr_q == '0) begin
      eff_word = WORD_BITS'(1);
    end else begin
      eff_word = '0;
    end
  end

  // lowest free bit of the current word
  always_comb begin
    hit_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!eff_word[i]) begin
        hit_bit = BW'(i);
      end
    end
  end

  assign word_full    = &eff_word;
  assign hit_frame    = {rd_addr_q, hit_bit};
  assign hit_ext      = {{FW{1'b0}}, hit_frame};
  assign hit_in_range = 32'(hit_frame) < 32'(NUM_FRAMES);
  assign last_word    = rd_addr_q == AW'(MAP_WORDS - 1);
  assign set_word     = eff_word | (WORD_BITS'(1) << hit_bit);
  assign clr_word     = eff_word & ~(WORD_BITS'(1) << page_frame[BW-1:0]);

  // status to controller
  assign sts.is_free    = req_type == fba_pkg::REQ_FREE;
  assign sts.frame_zero = page_frame == '0;
  assign sts.frame_bad  = 32'(page_frame) >= 32'(NUM_FRAMES);
  assign sts.scan_stop  = !word_full || last_word;
  assign sts.out_free   = !m_tvalid || m_tready;

  // request latch and read address tracking
  always_ff @(posedge clk) begin
    rd_addr_q <= rd_addr;
    if (cmd.load_req) begin
      req_type    <= s_tuser[0];
      page_frame  <= s_tdata[FW-1:0];
      kernel_page <= s_tdata[12];
      is_wr       <= s_tdata[13];
    end
  end

  // staged write and result
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pend <= 1'b0;
    end else if (cmd.load_req) begin
      wr_pend <= 1'b0;
    end else if (cmd.free_mod) begin
      wr_pend <= 1'b1;
    end else if (cmd.scan_step && !word_full && hit_in_range) begin
      wr_pend <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_nop) begin
      res_status  <= fba_pkg::ST_NOP;
      res_frame   <= (req_type == fba_pkg::REQ_FREE) ? '0 : page_frame;
      res_present <= 1'b0;
      res_rw      <= 1'b0;
      res_user    <= 1'b0;
    end else if (cmd.free_mod) begin
      wr_addr     <= rd_addr_q;
      wr_data     <= clr_word;
      res_status  <= fba_pkg::ST_DONE;
      res_frame   <= '0;
      res_present <= 1'b0;
      res_rw      <= 1'b0;
      res_user    <= 1'b0;
    end else if (cmd.scan_step) begin
      if (!word_full && hit_in_range) begin
        wr_addr     <= rd_addr_q;
        wr_data     <= set_word;
        res_status  <= fba_pkg::ST_DONE;
        res_frame   <= hit_ext[FW-1:0];
        res_present <= 1'b1;
        res_rw      <= is_wr;
        res_user    <= ~kernel_page;
      end else if (!word_full || last_word) begin
        // free bit lies past the last frame, or no word left
        res_status  <= fba_pkg::ST_FULL;
        res_frame   <= '0;
        res_present <= 1'b0;
        res_rw      <= 1'b0;
        res_user    <= 1'b0;
      end
    end
  end

  // per-word valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_map <= '0;
    end else if (cmd.commit && wr_pend) begin
      valid_map[wr_addr] <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tuser <= res_status;
      m_tdata <= {1'b0, res_user, res_rw, res_present, res_frame};
    end
  end

endmodule
`default_nettype wire

@@ src/fba_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fba_ctrl: allocator controller
// Sequences accept, dispatch, bitmap scan or free update, and result hand-off.
// ----------------------------------------------------------------------------
module fba_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire fba_pkg::sts_t sts,
  output fba_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DISP    = 3'd1;
  localparam logic [2:0] S_FREE_RD = 3'd2;
  localparam logic [2:0] S_SCAN    = 3'd3;
  localparam logic [2:0] S_DONE    = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready = state == S_IDLE;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_req = 1'b1;
          state_next   = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.is_free) begin
          if (sts.frame_zero || sts.frame_bad) begin
            cmd.set_nop = 1'b1;
            state_next  = S_DONE;
          end else begin
            cmd.free_rd = 1'b1;
            state_next  = S_FREE_RD;
          end
        end else if (!sts.frame_zero) begin
          cmd.set_nop = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_FREE_RD: begin
        cmd.free_mod = 1'b1;
        state_next   = S_DONE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_stop) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

@@ src/frame_bitmap_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frame_bitmap_allocator: first-fit physical frame allocator
// Requests arrive on the s_ stream: tuser[0] is the kind (0 allocate, 1 free),
// tdata carries the page's current frame and its kernel / writable flags.
// One result per request leaves on the m_ stream: tuser holds the status
// (done, nothing to do, no free frame), tdata the frame and the page flags.
// Allocation scans the bitmap RAM one word per cycle from word 0 through
// the single RAM read port and stops at the first non-full word or at the
// last of the MAP_WORDS words (128 with 4096 frames of 32-bit words). A
// free reads, modifies and writes back the word holding the frame; a
// request with nothing to do goes straight from dispatch to the result.
// One request is worked on at a time; the next one is accepted the cycle
// after the result is loaded.
// Reset empties the bitmap except frame 0 (kept as the no-frame mark)
// by clearing the per-word valid bits; no clearing pass is needed.
// If the receiver stalls, the result holds and the block stops before
// loading the next result.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator #(
  parameter int unsigned NUM_FRAMES = fba_pkg::NUM_FRAMES_DEF,
  parameter int unsigned WORD_BITS  = fba_pkg::WORD_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [0:0]  s_tuser,   // [0] req_type
  input  wire logic [15:0] s_tdata,   // [11:0] page_frame, [12] kernel_page,
                                      // [13] writable_page
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [1:0]       m_tuser,   // [1:0] status
  output logic [15:0]      m_tdata    // [11:0] frame_out, [12] present_bit, [13] rw_bit,
                                      // [14] user_bit
);

  fba_pkg::cmd_t cmd;
  fba_pkg::sts_t sts;

  // sequencer
  fba_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // bitmap and result datapath
  fba_dp #(
    .NUM_FRAMES(NUM_FRAMES),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .s_tuser (s_tuser),
    .s_tdata (s_tdata),
    .cmd     (cmd),
    .sts     (sts),
    .m_tready(m_tready),
    .m_tvalid(m_tvalid),
    .m_tuser (m_tuser),
    .m_tdata (m_tdata)
  );

`ifndef ASSERT_OFF
  // one request in flight: accept closes the input side
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while another is in flight");

  // present flag only comes with a completed allocation
  a_present_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[12]) |-> (m_tuser == fba_pkg::ST_DONE))
    else $error("present bit set on a result that is not done");

  // exhaustion reports no frame and no flags
  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == fba_pkg::ST_FULL) |-> (m_tdata[14:0] == '0))
    else $error("no-free-frame result carries a frame or flags");
`endif

endmodule
`default_nettype wire
